### src/lls_pkg.sv
// ----------------------------------------------------------------------------
// Line length statistics: shared package
// Types, constants and state codes used by the controller, the datapath,
// the divider and the top level of the line length statistics unit.
// ----------------------------------------------------------------------------
package lls_pkg;

  // Default values of the top level parameters.
  localparam int HIST_BUCKETS_DEF = 16;
  localparam int LENGTH_BITS_DEF  = 32;
  localparam int OFFSET_BITS_DEF  = 48;

  // Fixed widths of the counters, the length sum and the result fields.
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 48;
  localparam int STAT_IDX_W  = 5;
  localparam int STAT_VAL_W  = 48;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Text constants.
  localparam logic [7:0] NEWLINE = 8'd10;

  // Request opcodes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Long-line limits: 1 KiB, 10 KiB, 100 KiB and 1 MiB.
  localparam int NUM_LONG   = 4;
  localparam int LONG_SEL_W = 2;
  localparam logic [63:0] LONG_LIMITS [NUM_LONG] = '{
    64'd1024, 64'd10240, 64'd102400, 64'd1048576
  };

  // Upper bound of the first histogram bucket; later bounds double.
  localparam logic [63:0] HIST_BASE_LEN = 64'd64;

  // Statistic indexes of the report run.
  localparam int STAT_LINES     = 0;
  localparam int STAT_LONG_BASE = 1;
  localparam int STAT_LONG_TOP  = STAT_LONG_BASE + NUM_LONG - 1;
  localparam int STAT_MAX_LEN   = 5;
  localparam int STAT_MAX_OFS   = 6;
  localparam int STAT_AVERAGE   = 7;
  localparam int STAT_HIST_BASE = 8;

  // One input request.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } lls_item_t;

  // One result of the report run.
  typedef struct packed {
    logic [STAT_IDX_W-1:0] stat_index;
    logic [STAT_VAL_W-1:0] stat_value;
    logic                  overflow_seen;
    logic                  last;
  } lls_stat_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_START,
    ST_DIV,
    ST_REPORT
  } lls_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_take;
    logic div_start;
    logic rpt_clear;
    logic rpt_last;
  } lls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } lls_status_t;

endpackage

### src/lls_div.sv
// ----------------------------------------------------------------------------
// Line length statistics: average divider
// Restoring divider that yields one quotient bit per cycle. It divides the
// 48-bit length sum by the 32-bit line count.
// ----------------------------------------------------------------------------
module lls_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lls_pkg::SUM_W-1:0]  dividend,
  input  logic [lls_pkg::CNT_W-1:0]  divisor,
  output logic [lls_pkg::SUM_W-1:0]  quotient,
  output logic                       done
);

  logic [lls_pkg::CNT_W-1:0]     rem;
  logic [lls_pkg::SUM_W-1:0]     quo;
  logic [lls_pkg::DIV_CNT_W-1:0] steps;

  logic [lls_pkg::CNT_W:0]       shifted;
  logic                          fits;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem, quo[lls_pkg::SUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  // Step counter: the divider is busy while it is non-zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= lls_pkg::DIV_CNT_W'(lls_pkg::DIV_STEPS);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (steps != '0) begin
      if (fits) begin
        rem <= lls_pkg::CNT_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= lls_pkg::CNT_W'(shifted);
      end
      quo <= {quo[lls_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;
  assign done     = (steps == '0);

endmodule

### src/lls_datapath.sv
// ----------------------------------------------------------------------------
// Line length statistics: datapath
// Holds the statistics store. A first stage counts bytes and ends lines; a
// second stage folds each finished line into the counters, the histogram
// and the longest-line record. It also drives the report result.
// ----------------------------------------------------------------------------
module lls_datapath #(
  parameter int HIST_BUCKETS = lls_pkg::HIST_BUCKETS_DEF,
  parameter int LENGTH_BITS  = lls_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS  = lls_pkg::OFFSET_BITS_DEF,
  parameter int IDX_W        = $clog2(lls_pkg::STAT_HIST_BASE + HIST_BUCKETS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lls_pkg::lls_item_t   item,
  input  lls_pkg::lls_cmd_t    cmd,
  input  logic [IDX_W-1:0]     idx,
  output lls_pkg::lls_status_t status,
  output lls_pkg::lls_stat_t   stat
);

  localparam int HB_W = (HIST_BUCKETS > 1) ? $clog2(HIST_BUCKETS) : 1;
  localparam int CNT_W = lls_pkg::CNT_W;
  localparam int SUM_W = lls_pkg::SUM_W;

  // Store.
  logic [LENGTH_BITS-1:0] open_len;
  logic [OFFSET_BITS-1:0] line_start_offset;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [CNT_W-1:0]       line_count;
  logic [SUM_W-1:0]       length_sum;
  logic [CNT_W-1:0]       long_cnt [lls_pkg::NUM_LONG];
  logic [LENGTH_BITS-1:0] longest_length;
  logic [OFFSET_BITS-1:0] longest_offset;
  logic [CNT_W-1:0]       hist [HIST_BUCKETS];
  logic                   overflow_flag;

  // Line close stage register.
  logic                   close_vld;
  logic [LENGTH_BITS-1:0] close_len;
  logic [OFFSET_BITS-1:0] close_ofs;

  logic                   wipe;
  logic                   is_data;
  logic                   is_eos;
  logic                   len_full;
  logic                   ofs_full;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [OFFSET_BITS-1:0] ofs_inc;
  logic                   ovf_count;

  logic                   cnt_full;
  logic [SUM_W:0]         sum_wide;
  logic [lls_pkg::NUM_LONG-1:0] long_gt;
  logic [lls_pkg::NUM_LONG-1:0] long_full;
  logic [HIST_BUCKETS-1:0] hist_gt;
  logic [HIST_BUCKETS-1:0] hist_hit;
  logic [HIST_BUCKETS-1:0] hist_full;
  logic                   longer;
  logic                   ovf_close;

  logic [SUM_W-1:0]       quotient;
  logic                   div_done;
  logic [SUM_W-1:0]       average;
  logic [HB_W-1:0]        hist_sel;
  logic [lls_pkg::LONG_SEL_W-1:0] long_sel;
  logic [63:0]            ofs_wide;
  logic [lls_pkg::STAT_VAL_W-1:0] value;

  assign wipe    = rst | cmd.rpt_clear;
  assign is_data = cmd.item_take & (item.op == lls_pkg::OP_DATA);
  assign is_eos  = cmd.item_take & (item.op == lls_pkg::OP_EOS);

  // Saturating byte count and line length of the first stage.
  assign len_full  = &open_len;
  assign ofs_full  = &byte_offset;
  assign len_inc   = len_full ? open_len : open_len + LENGTH_BITS'(1);
  assign ofs_inc   = ofs_full ? byte_offset : byte_offset + OFFSET_BITS'(1);
  assign ovf_count = is_data & (len_full | ofs_full);

  // First stage: count the byte and hand a finished line to the close stage.
  always_ff @(posedge clk) begin
    if (wipe) begin
      open_len          <= '0;
      line_start_offset <= '0;
      byte_offset       <= '0;
      close_vld         <= 1'b0;
    end else if (is_data) begin
      byte_offset <= ofs_inc;
      if (item.data_byte == lls_pkg::NEWLINE) begin
        close_vld         <= 1'b1;
        open_len          <= '0;
        line_start_offset <= ofs_inc;
      end else begin
        close_vld <= 1'b0;
        open_len  <= len_inc;
      end
    end else if (is_eos) begin
      // An unterminated line is closed as it stands.
      close_vld <= (open_len != '0);
      open_len  <= '0;
    end else begin
      close_vld <= 1'b0;
    end
  end

  // Length and start of the line that is being closed.
  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      close_len <= (item.op == lls_pkg::OP_DATA) ? len_inc : open_len;
      close_ofs <= line_start_offset;
    end
  end

  // Second stage: classify the finished line.
  assign cnt_full = &line_count;
  assign sum_wide = {1'b0, length_sum} + (SUM_W + 1)'(close_len);
  assign longer   = close_len > longest_length;

  for (genvar gk = 0; gk < lls_pkg::NUM_LONG; gk++) begin : g_long_cmp
    assign long_gt[gk]   = 64'(close_len) > lls_pkg::LONG_LIMITS[gk];
    assign long_full[gk] = &long_cnt[gk];
  end

  // A line falls in the first bucket whose bound it does not exceed.
  for (genvar gb = 0; gb < HIST_BUCKETS; gb++) begin : g_hist_cmp
    if (gb < HIST_BUCKETS - 1) begin : g_bound
      assign hist_gt[gb] = 64'(close_len) > (lls_pkg::HIST_BASE_LEN << gb);
    end else begin : g_open
      assign hist_gt[gb] = 1'b0;
    end
    if (gb == 0) begin : g_first
      assign hist_hit[gb] = ~hist_gt[gb];
    end else begin : g_next
      assign hist_hit[gb] = hist_gt[gb-1] & ~hist_gt[gb];
    end
    assign hist_full[gb] = &hist[gb];
  end

  assign ovf_close = close_vld & (cnt_full | sum_wide[SUM_W] |
                                  (|(long_gt & long_full)) |
                                  (|(hist_hit & hist_full)));

  // Line count, length sum and longest line.
  always_ff @(posedge clk) begin
    if (wipe) begin
      line_count     <= '0;
      length_sum     <= '0;
      longest_length <= '0;
      longest_offset <= '0;
    end else if (close_vld) begin
      if (!cnt_full) begin
        line_count <= line_count + CNT_W'(1);
      end
      length_sum <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      if (longer) begin
        longest_length <= close_len;
        longest_offset <= close_ofs;
      end
    end
  end

  // Long-line counters.
  always_ff @(posedge clk) begin
    for (int k = 0; k < lls_pkg::NUM_LONG; k++) begin
      if (wipe) begin
        long_cnt[k] <= '0;
      end else if (close_vld && long_gt[k] && !long_full[k]) begin
        long_cnt[k] <= long_cnt[k] + CNT_W'(1);
      end
    end
  end

  // Histogram bucket counters.
  for (genvar gh = 0; gh < HIST_BUCKETS; gh++) begin : g_hist
    always_ff @(posedge clk) begin
      if (wipe) begin
        hist[gh] <= '0;
      end else if (close_vld && hist_hit[gh] && !hist_full[gh]) begin
        hist[gh] <= hist[gh] + CNT_W'(1);
      end
    end
  end

  // Sticky overflow flag.
  always_ff @(posedge clk) begin
    if (wipe) begin
      overflow_flag <= 1'b0;
    end else if (ovf_count || ovf_close) begin
      overflow_flag <= 1'b1;
    end
  end

  // Average length.
  lls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (length_sum),
    .divisor  (line_count),
    .quotient (quotient),
    .done     (div_done)
  );

  assign average       = (line_count == '0) ? '0 : quotient;
  assign status.div_done = div_done;

  // Report readout.
  assign ofs_wide = 64'(longest_offset);

  always_comb begin
    hist_sel = HB_W'(idx - IDX_W'(lls_pkg::STAT_HIST_BASE));
    long_sel = lls_pkg::LONG_SEL_W'(idx - IDX_W'(lls_pkg::STAT_LONG_BASE));
    case (idx) inside
      lls_pkg::STAT_LINES: begin
        value = lls_pkg::STAT_VAL_W'(line_count);
      end
      [lls_pkg::STAT_LONG_BASE:lls_pkg::STAT_LONG_TOP]: begin
        value = lls_pkg::STAT_VAL_W'(long_cnt[long_sel]);
      end
      lls_pkg::STAT_MAX_LEN: begin
        value = lls_pkg::STAT_VAL_W'(longest_length);
      end
      lls_pkg::STAT_MAX_OFS: begin
        value = ofs_wide[lls_pkg::STAT_VAL_W-1:0];
      end
      lls_pkg::STAT_AVERAGE: begin
        value = average;
      end
      default: begin
        value = lls_pkg::STAT_VAL_W'(hist[hist_sel]);
      end
    endcase
  end

  assign stat.stat_index    = lls_pkg::STAT_IDX_W'(idx);
  assign stat.stat_value    = value;
  assign stat.overflow_seen = overflow_flag;
  assign stat.last          = cmd.rpt_last;

endmodule

### src/lls_ctrl.sv
// ----------------------------------------------------------------------------
// Line length statistics: controller
// Takes requests while idle. At end of stream it lets the last line close,
// runs the divider and then steps through the report run.
// ----------------------------------------------------------------------------
module lls_ctrl #(
  parameter int HIST_BUCKETS = lls_pkg::HIST_BUCKETS_DEF,
  parameter int IDX_W        = $clog2(lls_pkg::STAT_HIST_BASE + HIST_BUCKETS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_op,
  output logic                 item_stall,
  output logic                 stat_valid,
  input  logic                 stat_stall,
  input  lls_pkg::lls_status_t status,
  output lls_pkg::lls_cmd_t    cmd,
  output logic [IDX_W-1:0]     idx
);

  localparam logic [IDX_W-1:0] IDX_LAST =
    IDX_W'(lls_pkg::STAT_HIST_BASE + HIST_BUCKETS - 1);

  lls_pkg::lls_state_t state;
  lls_pkg::lls_state_t state_next;
  logic [IDX_W-1:0]    idx_next;

  // State and report index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lls_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    item_stall    = 1'b1;
    stat_valid    = 1'b0;
    cmd           = '0;
    cmd.rpt_last  = (idx == IDX_LAST);
    case (state)
      lls_pkg::ST_IDLE: begin
        item_stall    = 1'b0;
        cmd.item_take = item_valid;
        if (item_valid && item_op == lls_pkg::OP_EOS) begin
          state_next = lls_pkg::ST_CLOSE;
        end
      end
      lls_pkg::ST_CLOSE: begin
        // The last line is folded into the store in this cycle.
        state_next = lls_pkg::ST_START;
      end
      lls_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = lls_pkg::ST_DIV;
      end
      lls_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = lls_pkg::ST_REPORT;
        end
      end
      lls_pkg::ST_REPORT: begin
        stat_valid = 1'b1;
        if (!stat_stall) begin
          if (idx == IDX_LAST) begin
            cmd.rpt_clear = 1'b1;
            idx_next      = '0;
            state_next    = lls_pkg::ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = lls_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/line_length_statistics_unit.sv
// ----------------------------------------------------------------------------
// Line length statistics unit
// Gathers line statistics over a byte stream and reports them at its end.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel, one text byte per request with op
// set to data, and a byte of 10 ending a line. Data requests are taken one
// per cycle and produce no result. A request with op set to end of stream
// closes any open line and starts the report: the item channel stalls
// while the report is built and delivered.
// The report is a run of 8 + HIST_BUCKETS results on the stat channel,
// one per cycle while the receiver does not stall, with last set on the
// final one. After the end-of-stream request is taken, the unit folds in
// the last line, starts the average, runs the one-bit-per-cycle divider
// and then moves on to the report and shows its first result.
// While the receiver stalls, the current result holds and nothing else
// advances. When the last result is taken the whole store is cleared and
// the unit takes requests again in the next cycle. Reset clears the store
// at once and leaves the unit ready for requests.
// ----------------------------------------------------------------------------
module line_length_statistics_unit #(
  parameter int HIST_BUCKETS = lls_pkg::HIST_BUCKETS_DEF,
  parameter int LENGTH_BITS  = lls_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS  = lls_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lls_pkg::lls_item_t item,
  output logic               stat_valid,
  input  logic               stat_stall,
  output lls_pkg::lls_stat_t stat
);

  localparam int IDX_W = $clog2(lls_pkg::STAT_HIST_BASE + HIST_BUCKETS);

  lls_pkg::lls_cmd_t    cmd;
  lls_pkg::lls_status_t status;
  logic [IDX_W-1:0]     idx;

  // Sequencing of requests, divide and report.
  lls_ctrl #(
    .HIST_BUCKETS (HIST_BUCKETS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.op),
    .item_stall (item_stall),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .status     (status),
    .cmd        (cmd),
    .idx        (idx)
  );

  // Statistics store, divider and readout.
  lls_datapath #(
    .HIST_BUCKETS (HIST_BUCKETS),
    .LENGTH_BITS  (LENGTH_BITS),
    .OFFSET_BITS  (OFFSET_BITS),
    .IDX_W        (IDX_W)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .idx    (idx),
    .status (status),
    .stat   (stat)
  );

endmodule

### src/lls_checker.sv
// ----------------------------------------------------------------------------
// Line length statistics: port checker
// Watches the ports of the unit and checks how the report run unfolds.
// ----------------------------------------------------------------------------
module lls_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input lls_pkg::lls_item_t item,
  input logic               stat_valid,
  input logic               stat_stall,
  input lls_pkg::lls_stat_t stat
);

  // A stalled result stays shown and unchanged.
  a_stat_hold: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat_stall |=> stat_valid && $stable(stat))
    else $error("stalled result changed or was dropped");

  // An end-of-stream request stalls the item channel in the next cycle.
  a_eos_stall: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == lls_pkg::OP_EOS |=> item_stall)
    else $error("request taken during report build");

  // A report run starts with the line count.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(stat_valid) |-> stat.stat_index == lls_pkg::STAT_IDX_W'(lls_pkg::STAT_LINES))
    else $error("report run did not start at index zero");

  // Results of a run follow one another in index order.
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    stat_valid && !stat_stall && !stat.last |=>
      stat_valid && stat.stat_index == lls_pkg::STAT_IDX_W'($past(stat.stat_index) + 1'b1))
    else $error("report run skipped or repeated an index");

  // The run ends after its last result.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    stat_valid && !stat_stall && stat.last |=> !stat_valid)
    else $error("result shown after the last one");

endmodule

bind line_length_statistics_unit lls_checker u_lls_checker (.*);

### tb/sv/line_stats_checker.sv
// ----------------------------------------------------------------------------
// Line length statistics checker
// Watches the request and statistics channels of the line length statistics
// unit, keeps its own copy of the line statistics, and compares every
// report entry with the predicted one in order, counting each mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_stats_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  lls_pkg::lls_item_t item,
  input  logic               stat_valid,
  input  logic               stat_stall,
  input  lls_pkg::lls_stat_t stat,
  output int                 mismatches,
  output int                 stats_waiting,
  output int                 stats_checked
);

  localparam int BUCKETS    = lls_pkg::HIST_BUCKETS_DEF;
  localparam int LEN_W      = lls_pkg::LENGTH_BITS_DEF;
  localparam int OFS_W      = lls_pkg::OFFSET_BITS_DEF;
  localparam int CNT_W      = lls_pkg::CNT_W;
  localparam int SUM_W      = lls_pkg::SUM_W;
  localparam int VAL_W      = lls_pkg::STAT_VAL_W;
  localparam int REPORT_LEN = lls_pkg::STAT_HIST_BASE + BUCKETS;

  // Predicted line statistics of the stream in progress.
  logic [LEN_W-1:0] cur_len;
  logic [OFS_W-1:0] cur_start;
  logic [OFS_W-1:0] next_ofs;
  logic [CNT_W-1:0] line_total;
  logic [SUM_W-1:0] len_total;
  logic [CNT_W-1:0] long_lines [lls_pkg::NUM_LONG];
  logic [LEN_W-1:0] top_len;
  logic [OFS_W-1:0] top_start;
  logic [CNT_W-1:0] len_buckets [BUCKETS];
  logic             saturated;

  // Report entries predicted but not yet delivered, oldest first.
  lls_pkg::lls_stat_t upcoming_stats [$];

  task automatic report_error(input string msg);
    $display("[%0t] line stats: %s", $time, msg);
    mismatches++;
  endtask

  // Counters stop at all ones and mark the stream as saturated.
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
    if (&v) begin
      saturated = 1'b1;
      return v;
    end
    return v + 1'b1;
  endfunction

  task automatic clear_store();
    cur_len    = '0;
    cur_start  = '0;
    next_ofs   = '0;
    line_total = '0;
    len_total  = '0;
    top_len    = '0;
    top_start  = '0;
    saturated  = 1'b0;
    for (int k = 0; k < lls_pkg::NUM_LONG; k++) long_lines[k] = '0;
    for (int k = 0; k < BUCKETS; k++) len_buckets[k] = '0;
  endtask

  // Fold the finished line into the totals, thresholds, histogram and record.
  task automatic fold_line();
    logic [63:0]    bound;
    logic [SUM_W:0] sum;
    int             b;
    bound = lls_pkg::HIST_BASE_LEN;
    b = 0;
    line_total = sat_count(line_total);
    sum = {1'b0, len_total} + (SUM_W + 1)'(cur_len);
    if (sum[SUM_W]) begin
      len_total = '1;
      saturated = 1'b1;
    end else begin
      len_total = sum[SUM_W-1:0];
    end
    for (int k = 0; k < lls_pkg::NUM_LONG; k++) begin
      if (64'(cur_len) > lls_pkg::LONG_LIMITS[k]) long_lines[k] = sat_count(long_lines[k]);
    end
    while (b + 1 < BUCKETS && 64'(cur_len) > bound) begin
      b++;
      bound = bound << 1;
    end
    len_buckets[b] = sat_count(len_buckets[b]);
    // The earliest of equally long lines is kept.
    if (cur_len > top_len) begin
      top_len   = cur_len;
      top_start = cur_start;
    end
    cur_len = '0;
  endtask

  // Advance the prediction by one accepted request.
  task automatic apply_request(input lls_pkg::lls_item_t req);
    lls_pkg::lls_stat_t e;
    if (req.op == lls_pkg::OP_DATA) begin
      if (&cur_len) saturated = 1'b1;
      else cur_len++;
      if (&next_ofs) saturated = 1'b1;
      else next_ofs++;
      if (req.data_byte == lls_pkg::NEWLINE) begin
        fold_line();
        cur_start = next_ofs;
      end
    end else begin
      // End of stream closes an open line, then the whole store is reported.
      if (cur_len != '0) fold_line();
      for (int k = 0; k < REPORT_LEN; k++) begin
        e.stat_index = k[lls_pkg::STAT_IDX_W-1:0];
        if (k == lls_pkg::STAT_LINES) begin
          e.stat_value = VAL_W'(line_total);
        end else if (k <= lls_pkg::STAT_LONG_TOP) begin
          e.stat_value = VAL_W'(long_lines[k - lls_pkg::STAT_LONG_BASE]);
        end else if (k == lls_pkg::STAT_MAX_LEN) begin
          e.stat_value = VAL_W'(top_len);
        end else if (k == lls_pkg::STAT_MAX_OFS) begin
          e.stat_value = top_start[VAL_W-1:0];
        end else if (k == lls_pkg::STAT_AVERAGE) begin
          e.stat_value = (line_total == '0) ? '0 : VAL_W'(len_total / SUM_W'(line_total));
        end else begin
          e.stat_value = VAL_W'(len_buckets[k - lls_pkg::STAT_HIST_BASE]);
        end
        e.overflow_seen = saturated;
        e.last = (k == REPORT_LEN - 1);
        upcoming_stats.push_back(e);
      end
      clear_store();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want, input int idx);
    if (got !== want)
      report_error($sformatf("entry %0d %s: got 0x%0h, expected 0x%0h",
                             idx, name, got, want));
  endtask

  task automatic check_result(input lls_pkg::lls_stat_t got);
    lls_pkg::lls_stat_t want;
    if (upcoming_stats.size() == 0) begin
      report_error($sformatf("result with index %0d arrived with none pending",
                             got.stat_index));
    end else begin
      want = upcoming_stats.pop_front();
      stats_checked++;
      compare_field("stat_index", 64'(got.stat_index), 64'(want.stat_index),
                    int'(want.stat_index));
      compare_field("stat_value", 64'(got.stat_value), 64'(want.stat_value),
                    int'(want.stat_index));
      compare_field("overflow_seen", 64'(got.overflow_seen), 64'(want.overflow_seen),
                    int'(want.stat_index));
      compare_field("last", 64'(got.last), 64'(want.last), int'(want.stat_index));
    end
  endtask

  // Sample both channels on each rising edge, results before requests.
  always @(posedge clk) begin
    if (rst) begin
      clear_store();
      upcoming_stats.delete();
    end else begin
      if (stat_valid && !stat_stall) check_result(stat);
      if (item_valid && !item_stall) apply_request(item);
    end
    stats_waiting = upcoming_stats.size();
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Line length statistics unit testbench
// Drives byte streams into the unit: a few directed streams for the edge
// cases, then random well-formed and noisy streams under changing idle and
// stall rates. A checker module predicts and compares every report; this
// module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 20;

  logic               clk;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  lls_pkg::lls_item_t item = '0;
  logic               stat_valid;
  logic               stat_stall = 1'b0;
  lls_pkg::lls_stat_t stat;

  int idle_pct = 30;
  int stall_pct = 85;
  int requests_sent = 0;
  int streams_sent = 0;
  int longest_sent = 0;
  int mismatches;
  int stats_waiting;
  int stats_checked;

  line_length_statistics_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .stat_valid(stat_valid),
    .stat_stall(stat_stall),
    .stat      (stat)
  );

  line_stats_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .stat_valid   (stat_valid),
    .stat_stall   (stat_stall),
    .stat         (stat),
    .mismatches   (mismatches),
    .stats_waiting(stats_waiting),
    .stats_checked(stats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver side: random stalls on the statistics channel.
  always @(posedge clk) begin
    stat_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one request after random idle cycles and hold it until taken.
  task automatic send_req(input logic op, input logic [7:0] data);
    lls_pkg::lls_item_t req;
    req.op = op;
    req.data_byte = data;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Any byte but a newline, uniformly.
  function automatic logic [7:0] text_byte();
    logic [7:0] v;
    v = 8'($urandom_range(254));
    if (v >= lls_pkg::NEWLINE) v = v + 8'd1;
    return v;
  endfunction

  task automatic send_line(input int len, input bit ended);
    for (int i = 1; i < len; i++) send_req(lls_pkg::OP_DATA, text_byte());
    send_req(lls_pkg::OP_DATA, ended ? lls_pkg::NEWLINE : text_byte());
    if (len > longest_sent) longest_sent = len;
  endtask

  task automatic end_stream(input logic [7:0] ignored);
    send_req(lls_pkg::OP_EOS, ignored);
    streams_sent++;
  endtask

  // Hold off new requests until the whole report has been delivered.
  task automatic wait_for_report();
    item_valid <= 1'b0;
    @(posedge clk);
    while (stats_waiting != 0) @(posedge clk);
  endtask

  // Mostly short lines, some around the first two histogram bounds.
  function automatic int pick_length();
    case ($urandom_range(9))
      8:       return $urandom_range(1) ? int'($urandom_range(66, 62)) :
                                          int'($urandom_range(130, 126));
      default: return int'($urandom_range(12, 1));
    endcase
  endfunction

  task automatic random_stream();
    int lines;
    int n;
    if ($urandom_range(4) == 0) begin
      // Noise: raw bytes with frequent newlines.
      n = int'($urandom_range(20));
      repeat (n) send_req(lls_pkg::OP_DATA, ($urandom_range(3) == 0) ?
                          lls_pkg::NEWLINE : 8'($urandom_range(255)));
    end else begin
      lines = int'($urandom_range(4));
      for (int i = 0; i < lines; i++)
        send_line(pick_length(), (i < lines - 1) || ($urandom_range(2) != 0));
    end
    end_stream(8'($urandom_range(255)));
  endtask

  task automatic run_phase(input int goal);
    int first_req;
    int first_stream;
    first_req = requests_sent;
    first_stream = streams_sent;
    while (requests_sent - first_req < goal || streams_sent - first_stream < 2)
      random_stream();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // An empty stream reports all zeros; then wait for the whole report.
    end_stream(8'hFF);
    wait_for_report();

    // Single newline, two tied longest lines, an unterminated tail.
    send_line(1, 1'b1);
    send_req(lls_pkg::OP_DATA, 8'hFF);
    send_req(lls_pkg::OP_DATA, 8'h00);
    send_req(lls_pkg::OP_DATA, lls_pkg::NEWLINE);
    send_req(lls_pkg::OP_DATA, 8'h55);
    send_req(lls_pkg::OP_DATA, 8'hAA);
    send_req(lls_pkg::OP_DATA, lls_pkg::NEWLINE);
    send_req(lls_pkg::OP_DATA, 8'h7E);
    end_stream(8'hFF);

    // Stream ending on a newline; the end-of-stream byte is ignored.
    send_req(lls_pkg::OP_DATA, lls_pkg::NEWLINE);
    send_req(lls_pkg::OP_DATA, lls_pkg::NEWLINE);
    end_stream(lls_pkg::NEWLINE);

    run_phase(40);

    idle_pct = 85;
    stall_pct = 30;
    run_phase(40);

    idle_pct = 0;
    stall_pct = 0;
    run_phase(40);

    item_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 20000 && stats_waiting != 0; n++) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Run covered %0d requests in %0d streams, longest line %0d bytes,",
             requests_sent, streams_sent, longest_sent);
    $display("with %0d statistics results compared and %0d mismatches.",
             stats_checked, mismatches);
    if (stats_waiting != 0)
      $display("%0d predicted statistics results never arrived.", stats_waiting);
    if (mismatches == 0 && stats_waiting == 0) begin
      $display("** line_length_statistics_unit: PASSED **");
    end else begin
      $display("** line_length_statistics_unit: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(10_000_000);
    $display("Timed out waiting for the unit.");
    $display("** line_length_statistics_unit: FAILED **");
    $finish;
  end

endmodule
